/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// ASSERT_SAME checks a consequence in the same cycle as its antecedent.
// ASSERT_NEXT checks a consequence in the cycle after its antecedent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/dllm_pkg.sv */
package dllm_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TARGET_AVG  = 1'b0;
    localparam logic CFG_TARGET_PEAK = 1'b1;

    localparam logic [7:0]  STALE_LIMIT_SECONDS = 8'd8;
    localparam logic [39:0] MIN_US              = 40'd5000;
    localparam logic [9:0]  HALF_MS_US          = 10'd500;
    localparam logic [62:0] SAT63               = {63{1'b1}};
    localparam logic [31:0] SAT32               = {32{1'b1}};

    // Millisecond conversion works one byte of the duration per cycle. The
    // reciprocal of 1000 is scaled by 2^28, which is exact for every partial
    // dividend below 2^18.
    localparam logic [9:0]  US_PER_MS = 10'd1000;
    localparam logic [18:0] MS_RECIP  = 19'd268436;
    localparam logic [2:0]  MS_DIGITS = 3'd4;

    // Shared divider geometry: 65-bit dividend, 34-bit divisor.
    localparam int DIV_N_W   = 65;
    localparam int DIV_D_W   = 34;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  elapsed_seconds;
        logic [39:0] total_us;
        logic [7:0]  sample_count;
    } in_word_t;

    typedef struct packed {
        logic [29:0] job_count;
        logic [60:0] avg_latency_ms;
        logic [60:0] peak_latency_ms;
        logic        overloaded;
    } out_word_t;

    typedef enum logic [1:0] {
        DIV_CAND = 2'd0,
        DIV_AVG  = 2'd1,
        DIV_PEAK = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     clear_all;
        logic     decay_step;
        logic     ms_init;
        logic     ms_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     apply_sample;
        logic     mul_load;
        logic     peak_update;
        logic     load_avg;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] secs;
        logic       cnt_zero;
        logic       div_done;
        logic       out_free;
    } dp_status_t;

endpackage

/* rtl/dllm_div.sv */
module dllm_div
    import dllm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    // Restoring divider, one quotient bit per cycle.
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     diff;
    logic                 ge;

    assign shifted  = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge       = shifted >= {1'b0, dvs_reg};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
    assign quo_next = {quo_reg[DIV_N_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/dllm_dp.sv */
`include "assert_macros.svh"

module dllm_dp
    import dllm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_word_t   in_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [31:0] cfg_data,
    input  ctrl_cmd_t  cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_stall,
    output out_word_t  out_data
);

    in_word_t    item_reg;
    logic [31:0] tgt_avg_reg;
    logic [31:0] tgt_peak_reg;
    logic [31:0] sw_reg, sw_next;
    logic [62:0] ls_reg, ls_next;
    logic [62:0] ps_reg, ps_next;
    logic [30:0] ms_reg;
    logic [62:0] prod_reg;
    logic [60:0] avg_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;
    logic [31:0] us_sh_reg;
    logic [30:0] mq_reg;
    logic [9:0]  mr_reg;

    logic               div_busy;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;

    logic [17:0] ms_part;
    logic [35:0] ms_prod;
    logic [7:0]  ms_digit;
    logic [17:0] ms_back;
    logic [17:0] ms_left;
    logic [30:0] ms_q;
    logic [9:0]  ms_r;
    logic        ms_up;
    logic [30:0] ms_val;
    logic [32:0] sw_sum;
    logic [32:0] sw_bias;
    logic [31:0] sw_decay;
    logic [63:0] ls_sum;
    logic [63:0] ps_sum;
    logic [62:0] cand;
    logic [60:0] peak_val;
    logic        over;
    logic        out_free;

    always_comb
    begin
        case (cmd.div_sel)
            DIV_CAND:
            begin
                div_dividend = {prod_reg, 2'b00};
                div_divisor  = {26'b0, item_reg.sample_count};
            end
            DIV_AVG:
            begin
                div_dividend = {2'b00, ls_reg};
                div_divisor  = {sw_reg, 2'b00};
            end
            DIV_PEAK:
            begin
                div_dividend = {2'b00, ps_reg};
                div_divisor  = {sw_reg, 2'b00};
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    dllm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // Long division by 1000, one byte per step. The running remainder stays
    // below 1000, so each partial dividend fits in 18 bits.
    assign ms_part  = {mr_reg, us_sh_reg[31:24]};
    assign ms_prod  = 36'(ms_part) * 36'(MS_RECIP);
    assign ms_digit = ms_prod[35:28];
    assign ms_back  = 18'(ms_digit) * 18'(US_PER_MS);
    assign ms_left  = ms_part - ms_back;

    // Microseconds to milliseconds, ties to even, short jobs count as zero.
    assign ms_q   = mq_reg;
    assign ms_r   = mr_reg;
    assign ms_up  = (ms_r > HALF_MS_US) || ((ms_r == HALF_MS_US) && ms_q[0]);
    assign ms_val = (item_reg.total_us < MIN_US) ? '0 : ms_q + {30'b0, ms_up};

    assign sw_sum   = {1'b0, sw_reg} + {25'b0, item_reg.sample_count};
    assign sw_bias  = {1'b0, sw_reg} + 33'd3;
    assign sw_decay = sw_reg - {1'b0, sw_bias[32:2]};
    assign ls_sum   = {1'b0, ls_reg} + {33'b0, ms_val};
    assign ps_sum   = {1'b0, ps_reg} + {33'b0, ms_val};
    assign cand     = (|div_quo[64:63]) ? SAT63 : div_quo[62:0];

    always_comb
    begin
        sw_next = sw_reg;
        ls_next = ls_reg;
        ps_next = ps_reg;
        if (cmd.clear_all)
        begin
            sw_next = '0;
            ls_next = '0;
            ps_next = '0;
        end
        else if (cmd.decay_step)
        begin
            sw_next = sw_decay;
            ls_next = ls_reg - {2'b00, ls_reg[62:2]};
            ps_next = ps_reg - {2'b00, ps_reg[62:2]};
        end
        else if (cmd.apply_sample)
        begin
            sw_next = sw_sum[32] ? SAT32 : sw_sum[31:0];
            ls_next = ls_sum[63] ? SAT63 : ls_sum[62:0];
            ps_next = ps_sum[63] ? SAT63 : ps_sum[62:0];
        end
        else if (cmd.peak_update)
        begin
            if (ps_reg < cand)
            begin
                ps_next = cand;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg       <= '0;
            ls_reg       <= '0;
            ps_reg       <= '0;
            tgt_avg_reg  <= '0;
            tgt_peak_reg <= '0;
        end
        else
        begin
            sw_reg <= sw_next;
            ls_reg <= ls_next;
            ps_reg <= ps_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TARGET_AVG:  tgt_avg_reg  <= cfg_data;
                    CFG_TARGET_PEAK: tgt_peak_reg <= cfg_data;
                    default:         tgt_avg_reg  <= tgt_avg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            item_reg <= in_data;
        end
        if (cmd.ms_init)
        begin
            us_sh_reg <= item_reg.total_us[31:0];
            mq_reg    <= '0;
            mr_reg    <= {2'b00, item_reg.total_us[39:32]};
        end
        else if (cmd.ms_step)
        begin
            us_sh_reg <= {us_sh_reg[23:0], 8'b0};
            mq_reg    <= {mq_reg[22:0], ms_digit};
            mr_reg    <= ms_left[9:0];
        end
        if (cmd.apply_sample)
        begin
            ms_reg <= ms_val;
        end
        if (cmd.mul_load)
        begin
            prod_reg <= 63'(sw_reg) * 63'(ms_reg);
        end
        if (cmd.load_avg)
        begin
            avg_reg <= (sw_reg == '0) ? '0 : div_quo[60:0];
        end
    end

    // Result stage: the peak quotient is still in the divider.
    assign peak_val = (sw_reg == '0) ? '0 : div_quo[60:0];
    assign over     = ((tgt_avg_reg != '0) && (avg_reg > {29'b0, tgt_avg_reg})) ||
                      ((tgt_peak_reg != '0) && (peak_val > {29'b0, tgt_peak_reg}));
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.job_count       <= sw_reg[31:2];
            out_data_reg.avg_latency_ms  <= avg_reg;
            out_data_reg.peak_latency_ms <= peak_val;
            out_data_reg.overloaded      <= over;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.opcode   = item_reg.opcode;
    assign status.secs     = item_reg.elapsed_seconds;
    assign status.cnt_zero = (item_reg.sample_count == '0);
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    `ASSERT_SAME(a_div_start_idle, clk, rst_n, cmd.div_start, !div_busy)
    `ASSERT_SAME(a_out_load_free, clk, rst_n, cmd.out_load, out_free)
    `ASSERT_SAME(a_ms_rem_range, clk, rst_n, cmd.ms_step, mr_reg < US_PER_MS)
    `ASSERT_NEXT(a_sample_weight_nonzero, clk, rst_n, cmd.apply_sample, sw_reg != '0)

endmodule

/* rtl/dllm_ctrl.sv */
`include "assert_macros.svh"

module dllm_ctrl
    import dllm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE       = 12'b0000_0000_0001,
        S_DISPATCH   = 12'b0000_0000_0010,
        S_DECAY      = 12'b0000_0000_0100,
        S_MS_CONV    = 12'b0000_0000_1000,
        S_SAMPLE_ADD = 12'b0000_0001_0000,
        S_MUL        = 12'b0000_0010_0000,
        S_CAND_GO    = 12'b0000_0100_0000,
        S_CAND_DIV   = 12'b0000_1000_0000,
        S_PEAK_MAX   = 12'b0001_0000_0000,
        S_AVG_DIV    = 12'b0010_0000_0000,
        S_PEAK_DIV   = 12'b0100_0000_0000,
        S_RESULT     = 12'b1000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [7:0] secs_reg, secs_next;
    logic [2:0] digit_reg, digit_next;

    always_comb
    begin
        state_next = state_reg;
        secs_next  = secs_reg;
        digit_next = digit_reg;
        cmd        = '0;
        cmd.div_sel = DIV_CAND;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.opcode)
                    OP_TICK:
                    begin
                        if (status.secs == '0)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (status.secs > STALE_LIMIT_SECONDS)
                        begin
                            cmd.clear_all = 1'b1;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            secs_next  = status.secs;
                            state_next = S_DECAY;
                        end
                    end
                    OP_SAMPLE:
                    begin
                        if (status.cnt_zero)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.ms_init = 1'b1;
                            digit_next  = MS_DIGITS;
                            state_next  = S_MS_CONV;
                        end
                    end
                    OP_QUERY:
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = DIV_AVG;
                        state_next    = S_AVG_DIV;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DECAY:
            begin
                cmd.decay_step = 1'b1;
                secs_next      = secs_reg - 1'b1;
                if (secs_reg == 8'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MS_CONV:
            begin
                cmd.ms_step = 1'b1;
                digit_next  = digit_reg - 1'b1;
                if (digit_reg == 3'd1)
                begin
                    state_next = S_SAMPLE_ADD;
                end
            end
            S_SAMPLE_ADD:
            begin
                cmd.apply_sample = 1'b1;
                state_next       = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_CAND_GO;
            end
            S_CAND_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_CAND;
                state_next    = S_CAND_DIV;
            end
            S_CAND_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_PEAK_MAX;
                end
            end
            S_PEAK_MAX:
            begin
                cmd.peak_update = 1'b1;
                state_next      = S_IDLE;
            end
            S_AVG_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.load_avg  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_PEAK;
                    state_next    = S_PEAK_DIV;
                end
            end
            S_PEAK_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            secs_reg  <= '0;
            digit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            secs_reg  <= secs_next;
            digit_reg <= digit_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `ASSERT_SAME(a_decay_count_live, clk, rst_n, state_reg == S_DECAY, secs_reg != '0)
    `ASSERT_NEXT(a_accept_dispatch, clk, rst_n, cmd.load_in, state_reg == S_DISPATCH)

endmodule

/* rtl/decaying_latency_load_monitor_core.sv */
// Each accepted word holds the input until the controller is back in idle; a
// tick decays once per elapsed second, and a query presents its result word
// in the same cycle as the next word can be taken.
// Throughput: one input word at a time; the radix-2 divider sets the cost, run
// once per sample and twice per query.
// Reset (rst_n, asynchronous, active low) clears the accumulators, the targets,
// the controller and the output valid; the block is ready on the next cycle.
module decaying_latency_load_monitor_core
    import dllm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    // The controller sequences each word: ticks run the decay loop once per elapsed
    // second or clear everything past the stale limit, samples convert the duration
    // to milliseconds one byte per cycle with a reciprocal multiply, update the
    // accumulators, and form the peak candidate with one multiply and a division, and
    // queries divide both sums by four times the sample weight.
    // The datapath holds the accumulators, the divider and the output register,
    // so a finished query word can wait there while the next word is taken.

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dllm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    dllm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* bench/decaying_latency_load_monitor_core_test.sv */
`timescale 1ns / 1ps

module decaying_latency_load_monitor_core_test;
    import dllm_pkg::*;

    // The package names three operations; the fourth encoding must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // A sample gives no result word, so before any register write the bench lets
    // SETTLE_CYCLES pass after the last expected result has arrived, for the last
    // sample to finish inside the block.
    localparam int SETTLE_CYCLES = 200;

    // The slowest correct run is roughly 820 words, each as slow as a query, plus
    // the longest sender gaps and receiver stalls. The limit is several times that.
    localparam int CYCLE_LIMIT = 1000000;

    localparam int RANDOM_PHASES = 5;
    localparam int WORDS_PER_PHASE = 125;

    // Tracks the three decaying accumulators and the two targets, and keeps the
    // statistics words that queries are due to return, oldest first.
    class load_scoreboard;
        bit [63:0] weight;
        bit [63:0] latency_acc;
        bit [63:0] peak_acc;
        bit [31:0] avg_target;
        bit [31:0] peak_target;
        out_word_t expected_stats[$];
        int fail_count;
        int n_tick;
        int n_sample;
        int n_query;
        int n_ignored;
        int n_over;
        int n_checked;

        function void set_targets(bit [31:0] avg_ms, bit [31:0] peak_ms);
            avg_target = avg_ms;
            peak_target = peak_ms;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        task report_mismatch(string what);
            fail_count++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Durations under 5 ms count as zero; others round to nearest, ties to even.
        function bit [63:0] us_to_millis(bit [63:0] us);
            bit [63:0] q;
            bit [63:0] r;
            if (us < MIN_US)
                return 64'd0;
            q = us / 1000;
            r = us % 1000;
            if (r > HALF_MS_US || (r == HALF_MS_US && q[0]))
                q++;
            return q;
        endfunction

        function bit [63:0] clip63(bit [63:0] v);
            return (v > SAT63) ? 64'(SAT63) : v;
        endfunction

        function void apply_tick(bit [7:0] secs);
            if (secs == 0)
                return;
            if (secs > STALE_LIMIT_SECONDS) begin
                weight = 0;
                latency_acc = 0;
                peak_acc = 0;
                return;
            end
            for (int i = 0; i < secs; i++) begin
                // The quarter taken from the weight is rounded up.
                weight -= (weight + 3) / 4;
                latency_acc -= latency_acc / 4;
                peak_acc -= peak_acc / 4;
            end
        endfunction

        function void apply_sample(bit [39:0] us, bit [7:0] cnt);
            bit [63:0] ms;
            bit [63:0] prod;
            bit [63:0] q;
            bit [63:0] r;
            bit [63:0] cand;
            ms = us_to_millis(64'(us));
            weight += cnt;
            if (weight > SAT32)
                weight = 64'(SAT32);
            latency_acc = clip63(latency_acc + ms);
            peak_acc = clip63(peak_acc + ms);
            // The weight stays below 2^32 and ms below 2^31, so this cannot wrap.
            prod = weight * ms;
            q = prod / cnt;
            r = prod % cnt;
            if (q > (64'(SAT63) >> 2))
                cand = 64'(SAT63);
            else
                cand = clip63(q * 4 + (r * 4) / cnt);
            if (peak_acc < cand)
                peak_acc = cand;
        endfunction

        function void note_input(in_word_t w);
            out_word_t stats;
            bit [63:0] avg;
            bit [63:0] peak;
            case (w.opcode)
                OP_TICK:
                begin
                    n_tick++;
                    apply_tick(w.elapsed_seconds);
                end
                OP_SAMPLE:
                begin
                    if (w.sample_count == 0) begin
                        n_ignored++;
                    end
                    else begin
                        n_sample++;
                        apply_sample(w.total_us, w.sample_count);
                    end
                end
                OP_QUERY:
                begin
                    n_query++;
                    avg = 0;
                    peak = 0;
                    if (weight != 0) begin
                        avg = latency_acc / (weight * 4);
                        peak = peak_acc / (weight * 4);
                    end
                    stats.job_count = 30'(weight >> 2);
                    stats.avg_latency_ms = 61'(avg);
                    stats.peak_latency_ms = 61'(peak);
                    stats.overloaded = (avg_target != 0 && avg > avg_target) ||
                                       (peak_target != 0 && peak > peak_target);
                    if (stats.overloaded)
                        n_over++;
                    expected_stats.push_back(stats);
                end
                default:
                begin
                    n_ignored++;
                end
            endcase
        endfunction

        task check_result(out_word_t got);
            out_word_t want;
            if (expected_stats.size() == 0) begin
                report_mismatch($sformatf("statistics word with none expected: %h", got));
                return;
            end
            want = expected_stats.pop_front();
            n_checked++;
            if (got.job_count !== want.job_count)
                report_mismatch($sformatf("job_count got %0d want %0d",
                                          got.job_count, want.job_count));
            if (got.avg_latency_ms !== want.avg_latency_ms)
                report_mismatch($sformatf("avg_latency_ms got %0d want %0d",
                                          got.avg_latency_ms, want.avg_latency_ms));
            if (got.peak_latency_ms !== want.peak_latency_ms)
                report_mismatch($sformatf("peak_latency_ms got %0d want %0d",
                                          got.peak_latency_ms, want.peak_latency_ms));
            if (got.overloaded !== want.overloaded)
                report_mismatch($sformatf("overloaded got %b want %b",
                                          got.overloaded, want.overloaded));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_TARGET_AVG;
    logic [31:0] cfg_data = '0;

    load_scoreboard sb;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int settings_used = 0;

    decaying_latency_load_monitor_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL decaying_latency_load_monitor_core");
            $finish;
        end
    end

    // Both channels are sampled at the edge with their pre-edge values. The
    // result is checked before the input is noted so that the order is fixed.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (in_valid && !in_stall)
                sb.note_input(in_data);
        end
    end

    // Receiver back-pressure: mostly free-flowing, with short stalls and now
    // and then a long one. While rx_quiet is set the receiver starts no new stall.
    always @(posedge clk)
    begin
        int unsigned r;
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (rx_quiet || r < 60) begin
            out_stall <= 1'b0;
        end
        else if (r < 92) begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else begin
            stall_left = $urandom_range(5, 60);
            out_stall <= 1'b1;
        end
    end

    function automatic in_word_t make_word(logic [1:0] op, logic [7:0] secs,
                                           logic [39:0] us, logic [7:0] cnt);
        in_word_t w;
        w.opcode = op;
        w.elapsed_seconds = secs;
        w.total_us = us;
        w.sample_count = cnt;
        return w;
    endfunction

    // Presents one word and holds it until the block takes it. The valid is
    // left high so that a following word can go out back to back.
    task automatic send_word(in_word_t w);
        in_data <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Sender gap after a word: mostly none, some short, a few long.
    task automatic idle_gap();
        int unsigned r;
        int unsigned n;
        if (tx_quiet)
            return;
        r = $urandom_range(0, 99);
        if (r < 60)
            n = 0;
        else if (r < 92)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(5, 40);
        if (n != 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Holds the sender until every pending statistics word has come back.
    // The pending count is first read after waiting on the clock, so that a just-accepted query is noted first.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Writes both targets on back-to-back edges, only while the block is idle.
    task automatic write_targets(logic [31:0] avg_ms, logic [31:0] peak_ms);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TARGET_AVG;
        cfg_data <= avg_ms;
        @(posedge clk);
        cfg_index <= CFG_TARGET_PEAK;
        cfg_data <= peak_ms;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_targets(avg_ms, peak_ms);
        settings_used++;
    endtask

    // Random word. Most are well-formed ticks, samples and queries; durations
    // cluster around the rounding boundaries and small counts push the peak.
    function automatic in_word_t random_word();
        in_word_t w;
        int unsigned pick;
        int unsigned sub;
        int unsigned whole_ms;
        w.opcode = OP_QUERY;
        w.elapsed_seconds = 8'($urandom);
        w.total_us = {8'($urandom), 32'($urandom)};
        w.sample_count = 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            w.opcode = OP_SAMPLE;
            sub = $urandom_range(0, 9);
            if (sub < 2) begin
                w.total_us = 40'($urandom_range(4990, 12000));
            end
            else if (sub < 4) begin
                whole_ms = $urandom_range(4, 20);
                w.total_us = 40'(whole_ms * 1000 + 499 + $urandom_range(0, 2));
            end
            else if (sub < 8) begin
                w.total_us = 40'($urandom_range(0, 3000000));
            end
            if ($urandom_range(0, 1) == 0)
                w.sample_count = 8'($urandom_range(1, 8));
        end
        else if (pick < 70) begin
            w.opcode = OP_TICK;
            sub = $urandom_range(0, 99);
            if (sub < 70)
                w.elapsed_seconds = 8'($urandom_range(0, 3));
            else if (sub < 90)
                w.elapsed_seconds = 8'($urandom_range(4, STALE_LIMIT_SECONDS));
            else
                w.elapsed_seconds = 8'($urandom_range(STALE_LIMIT_SECONDS + 1, 255));
        end
        else if (pick >= 95) begin
            // Noise: the unused operation or a sample carrying no count.
            if ($urandom_range(0, 1) == 0) begin
                w.opcode = OP_UNUSED;
            end
            else begin
                w.opcode = OP_SAMPLE;
                w.sample_count = 8'd0;
            end
        end
        return w;
    endfunction

    // Short directed pass: rounding edges, extreme fields, ignored words,
    // zero, full and stale decay, and queries on an empty monitor.
    task automatic run_directed();
        in_word_t words[$];
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd4999, 8'd1));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd5000, 8'd1));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd5500, 8'd2));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd6500, 8'd3));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd6501, 8'd255));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd7499, 8'd1));
        words.push_back(make_word(OP_SAMPLE, 8'hff, {40{1'b1}}, 8'd255));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd123456, 8'd0));
        words.push_back(make_word(OP_UNUSED, 8'hff, {40{1'b1}}, 8'hff));
        words.push_back(make_word(OP_QUERY, 8'hff, {40{1'b1}}, 8'hff));
        words.push_back(make_word(OP_TICK, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_TICK, 8'd1, 40'd0, 8'd0));
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_TICK, STALE_LIMIT_SECONDS, 40'd0, 8'd0));
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd0, 8'd1));
        words.push_back(make_word(OP_TICK, STALE_LIMIT_SECONDS + 8'd1, 40'd0, 8'd0));
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_SAMPLE, 8'd0, 40'd1500000, 8'd4));
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        words.push_back(make_word(OP_TICK, 8'hff, 40'd0, 8'd0));
        words.push_back(make_word(OP_QUERY, 8'd0, 40'd0, 8'd0));
        foreach (words[i]) begin
            send_word(words[i]);
            idle_gap();
        end
    endtask

    // One random phase. Ignored words do not count toward the phase length.
    // Idling is switched off in stretches, and rarely the sender drains.
    task automatic run_random_phase();
        in_word_t w;
        int useful;
        useful = 0;
        while (useful < WORDS_PER_PHASE) begin
            if (useful % 40 == 0) begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            w = random_word();
            send_word(w);
            if (!(w.opcode == OP_UNUSED || (w.opcode == OP_SAMPLE && w.sample_count == 0)))
                useful++;
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            else
                idle_gap();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin
        sb = new;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Targets start at zero after reset, so the directed pass runs untargeted.
        run_directed();

        // Target settings: both at the top, explicitly cleared, the tightest
        // nonzero value, realistic values, and arbitrary 32-bit patterns.
        for (int phase = 0; phase < RANDOM_PHASES + 1; phase++) begin
            case (phase)
                0: write_targets({32{1'b1}}, {32{1'b1}});
                1: write_targets(32'd0, 32'd0);
                2: write_targets(32'd1, 32'd1);
                3: write_targets(32'($urandom_range(1, 3000)), 32'($urandom_range(1, 3000)));
                4: write_targets(32'($urandom), 32'd0);
                default: write_targets(32'd0, 32'($urandom_range(1, 3000)));
            endcase
            run_random_phase();
        end

        // Drain, then give the last tick or sample time to finish inside the block.
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d statistics words never arrived", sb.pending()));

        $display("covered %0d ticks, %0d samples, %0d queries (%0d overloaded), %0d ignored words",
                 sb.n_tick, sb.n_sample, sb.n_query, sb.n_over, sb.n_ignored);
        $display("checked %0d statistics words under %0d target settings, %0d mismatches",
                 sb.n_checked, settings_used, sb.fail_count);
        if (sb.fail_count == 0)
            $display("PASS decaying_latency_load_monitor_core");
        else
            $display("FAIL decaying_latency_load_monitor_core");
        $finish;
    end

endmodule
